// ===== design/sida_pkg.sv =====
// shared constants for the signed integer to decimal text converter
`timescale 1ns / 1ps

package sida_pkg;

  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned STAGE_BITS = 4;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// signed integer to decimal ascii text: pipelined double dabble feeding a character serializer
// each value is registered in every pipeline stage, then in the serializer; characters leave one per
// cycle while out_ready_i is high; an item of text length L (1..11 at 32 bits) holds the serializer
// until its last one goes; the conversion pipeline takes a new item every cycle until it backs up
// reset: rst_ni low clears all valid bits and the serializer state, no item is in flight after it
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  value_valid_i,
  output logic                  value_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            character_o,
  output logic                  last_char_o
);

  localparam int unsigned SB     = sida_pkg::STAGE_BITS;
  localparam int unsigned DB     = sida_pkg::DIGIT_BITS;
  localparam int unsigned NSTAGE = (VALUE_BITS + SB - 1) / SB;
  localparam int unsigned PAD_W  = NSTAGE * SB;
  localparam int unsigned NDIG   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W  = NDIG * DB;
  localparam int unsigned POS_W  = $clog2(NDIG);

  // one shift-and-correct step per magnitude bit, msb first
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
                                               input logic [SB-1:0]    bits);
    logic [BCD_W-1:0] b;
    b = bcd_in;
    for (int i = SB - 1; i >= 0; i--) begin
      for (int d = 0; d < NDIG; d++) begin
        if (b[d*DB +: DB] >= 4'd5) begin
          b[d*DB +: DB] = b[d*DB +: DB] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], bits[i]};
    end
    return b;
  endfunction

  logic             vld_q   [0:NSTAGE];
  logic             neg_q   [0:NSTAGE];
  logic [PAD_W-1:0] mag_q   [0:NSTAGE];
  logic [BCD_W-1:0] bcd_q   [0:NSTAGE];
  logic             stg_rdy [0:NSTAGE];

  logic             ser_vld_q;
  logic             ser_minus_q;
  logic [POS_W-1:0] ser_pos_q;
  logic [BCD_W-1:0] ser_bcd_q;
  logic             ser_rdy;
  logic             ser_load;
  logic             out_fire;
  logic [POS_W-1:0] top_pos;
  logic [DB-1:0]    cur_digit;

  logic [VALUE_BITS-1:0] in_mag;

  assign in_mag = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  // stage ready: empty, or the stage after it takes the item
  always_comb begin
    stg_rdy[NSTAGE] = !vld_q[NSTAGE] || ser_rdy;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign value_ready_o = stg_rdy[0];

  // input capture stage: sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (stg_rdy[0]) begin
      vld_q[0] <= value_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0] && value_valid_i) begin
      neg_q[0] <= value_i[VALUE_BITS-1];
      mag_q[0] <= PAD_W'(in_mag);
      bcd_q[0] <= '0;
    end
  end

  // conversion stages, SB magnitude bits each
  for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[k] && vld_q[k-1]) begin
        neg_q[k] <= neg_q[k-1];
        mag_q[k] <= mag_q[k-1] << SB;
        bcd_q[k] <= dabble(bcd_q[k-1], mag_q[k-1][PAD_W-1 -: SB]);
      end
    end
  end

  // most significant nonzero digit, or digit zero for a zero value
  always_comb begin
    top_pos = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (bcd_q[NSTAGE][d*DB +: DB] != '0) begin
        top_pos = POS_W'(d);
      end
    end
  end

  assign out_valid_o = ser_vld_q;
  assign last_char_o = !ser_minus_q && (ser_pos_q == '0);
  assign out_fire    = ser_vld_q && out_ready_i;
  assign ser_rdy     = !ser_vld_q || (out_ready_i && last_char_o);
  assign ser_load    = vld_q[NSTAGE] && ser_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q   <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_pos_q   <= '0;
    end else if (ser_load) begin
      ser_vld_q   <= 1'b1;
      ser_minus_q <= neg_q[NSTAGE];
      ser_pos_q   <= top_pos;
    end else if (out_fire) begin
      if (ser_minus_q) begin
        ser_minus_q <= 1'b0;
      end else if (ser_pos_q == '0) begin
        ser_vld_q <= 1'b0;
      end else begin
        ser_pos_q <= ser_pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q <= bcd_q[NSTAGE];
    end
  end

  assign cur_digit   = ser_bcd_q[ser_pos_q*DB +: DB];
  assign character_o = ser_minus_q ? sida_pkg::CH_MINUS
                                   : sida_pkg::CH_ZERO + {4'b0000, cur_digit};

endmodule

// ===== sim/signed_int_to_decimal_ascii_test.sv =====
// testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

  localparam int unsigned VALUE_BITS     = 32;
  localparam logic [31:0] RADIX          = 32'd10;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  value_valid_i = 1'b0;
  logic [VALUE_BITS-1:0] value_i       = '0;
  logic                  out_ready_i   = 1'b0;
  logic                  value_ready_o;
  logic                  out_valid_o;
  logic [7:0]            character_o;
  logic                  last_char_o;

  text_char_t expected_text_q[$];
  int         mismatches       = 0;
  int         stalled_cycles   = 0;
  bit         sender_idle_en   = 1'b1;
  bit         receiver_idle_en = 1'b1;
  bit         hold_req         = 1'b0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_valid_i(value_valid_i),
    .value_ready_o(value_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_char_o  (last_char_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected text of one value: optional minus, then digits msd first
  function automatic void push_decimal_text(input logic [31:0] v);
    logic       neg;
    logic [31:0] mag;
    logic [3:0] digs[10];
    int         n;
    int         k;
    text_char_t c;
    neg = v[31];
    mag = neg ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % RADIX);
      mag = mag / RADIX;
      n++;
    end while (mag != 32'd0);
    if (neg) begin
      c.ch = sida_pkg::CH_MINUS;
      c.last = 1'b0;
      expected_text_q.push_back(c);
    end
    for (k = n - 1; k >= 0; k--) begin
      c.ch = sida_pkg::CH_ZERO + 8'(digs[k]);
      c.last = (k == 0);
      expected_text_q.push_back(c);
    end
  endfunction

  // 10^k plus a small offset, either sign
  function automatic logic [31:0] decade_value();
    longint p;
    int     k;
    k = $urandom_range(0, 9);
    p = 1;
    repeat (k) p = p * 10;
    p = p + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 1) == 1) p = -p;
    return 32'(p);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] mag;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200)) - 100);
      2: return decade_value();
      default: begin
        mag = $urandom >> $urandom_range(0, 31);
        return ($urandom_range(0, 1) == 1) ? (~mag + 32'd1) : mag;
      end
    endcase
  endfunction

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = (sender_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      value_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    value_i       <= v;
    value_valid_i <= 1'b1;
    do @(posedge clk_i); while (!value_ready_o);
    push_decimal_text(v);
  endtask

  task automatic wait_for_text();
    @(negedge clk_i);
    value_valid_i <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
             32'h5555_5555, 32'hAAAA_AAAA, -32'sd9, 32'd42};
    foreach (vals[i]) send_value(vals[i]);
    wait_for_text();
  endtask

  task automatic test_random_values();
    repeat (200) send_value(random_value());
    wait_for_text();
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_value(random_value());
    wait_for_text();
  endtask

  task automatic test_full_rate();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (100) send_value(random_value());
    wait_for_text();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_values();
    test_backpressure();
    test_full_rate();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

  // output ready: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text_q.size() == 0) begin
        $error("unexpected character %0d last %0b", character_o, last_char_o);
        mismatches++;
      end else begin
        exp_c = expected_text_q.pop_front();
        if (character_o !== exp_c.ch) begin
          $error("character: expected %0d, got %0d", exp_c.ch, character_o);
          mismatches++;
        end
        if (last_char_o !== exp_c.last) begin
          $error("last_char: expected %0b, got %0b", exp_c.last, last_char_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((value_valid_i && value_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
design/sida_pkg.sv
design/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_test.sv
